@@ hdl/lfpa_pkg.sv @@
// shared types and constants of the lowest free page allocator
package lfpa_pkg;

   localparam int MODE_W      = 2;
   localparam int PAGE_W      = 10;
   localparam int STATUS_W    = 2;
   localparam int TOP_CNT_W   = 11;
   localparam int FREE_CNT_W  = 10;
   localparam int LIMIT_W     = 11;

   localparam int REQ_DATA_W  = 16;
   localparam int RSP_FIELD_W = PAGE_W + STATUS_W + 1 + TOP_CNT_W + FREE_CNT_W;
   localparam int RSP_DATA_W  = 40;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELOC = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // register index, taken from the word address bit of paddr
   localparam logic REG_PAGE_LIMIT = 1'b0;

   typedef struct packed {
      logic accept;
      logic eval;
      logic trim;
      logic issue;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic go_trim;
      logic go_realloc;
      logic trim_more;
      logic reloc;
   } dp_stat_type;

endpackage

@@ hdl/lowest_free_page_allocator_unit.sv @@
// top level of the lowest free page allocator
//
// The req channel takes one request word: allocate, free or relocate a page.
// The rsp channel returns one word for every request: the page, a status
// code, the limit flag and the top and free counts after the request.
// The csr port (APB style) holds the page limit register at address 0.
//
// The free bitmap is kept in a memory of 32-page rows with a registered
// read, plus one summary bit per row that marks a row holding free pages.
// A request is accepted and its bitmap row read, then evaluated and the row
// written back; its word is marked pending, then loaded into the rsp register.
// A free that trims the top walks down one further row per step of the trim
// state. A relocation that moves its page passes through an issue state and a
// second evaluation for the second row read, plus any trim rows.
// Reset sets top to 1 and clears the counts and the summary bits, so the
// whole bitmap reads as in use right away; there is no clearing pass.
// A stalled rsp keeps its word; one more request may be accepted and
// finished behind it, after which req_tready stays low until rsp moves.
module lowest_free_page_allocator_unit #(
   parameter int NUM_PAGES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode[1:0], page[11:2], zero fill
   input  logic [lfpa_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_page[9:0], status[11:10], limit_reached[12], top_count[23:13],
   // free_count[33:24], zero fill
   output logic [lfpa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lfpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lfpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lfpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import lfpa_pkg::*;

   ctl_cmd_type          cmd;
   dp_stat_type          stat;
   logic [LIMIT_W-1:0]   page_limit;

   lfpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .page_limit  (page_limit)
   );

   lfpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lfpa_dpath #(
      .NUM_PAGES (NUM_PAGES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .page_limit (page_limit),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hdl/lfpa_ram.sv @@
// generic single write port ram with registered read
module lfpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lfpa_csr.sv @@
// configuration register port holding the page limit
module lfpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lfpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lfpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lfpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [lfpa_pkg::LIMIT_W-1:0]     page_limit
);
   import lfpa_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               hit_limit;

   assign hit_limit  = csr_paddr[CSR_ADDR_W-1] == REG_PAGE_LIMIT;
   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit_limit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit_limit) begin
         csr_prdata = CSR_DATA_W'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign page_limit = limit_ff;

endmodule

@@ hdl/lfpa_ctrl.sv @@
// sequencer: handshakes, operation phases and result hand-off
module lfpa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  lfpa_pkg::dp_stat_type     stat,
   output lfpa_pkg::ctl_cmd_type     cmd
);
   import lfpa_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_TRIM  = 2'd2;
   localparam logic [1:0] S_ISSUE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       valid_ff, valid_in;
   logic       out_free;
   logic       finish;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && (!pend_ff || out_free);

   always_comb begin
      cmd          = '0;
      cmd.accept   = req_tvalid && req_tready;
      cmd.eval     = state_ff == S_EVAL;
      cmd.trim     = state_ff == S_TRIM;
      cmd.issue    = state_ff == S_ISSUE;
      cmd.load_out = pend_ff && out_free;
   end

   always_comb begin
      state_in = state_ff;
      finish   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.go_trim) begin
               state_in = S_TRIM;
            end else if (stat.go_realloc) begin
               state_in = S_ISSUE;
            end else begin
               state_in = S_IDLE;
               finish   = 1'b1;
            end
         end
         S_TRIM: begin
            if (!stat.trim_more) begin
               if (stat.reloc) begin
                  state_in = S_ISSUE;
               end else begin
                  state_in = S_IDLE;
                  finish   = 1'b1;
               end
            end
         end
         S_ISSUE: begin
            state_in = S_EVAL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      if (finish) begin
         pend_in = 1'b1;
      end else if (cmd.load_out) begin
         pend_in = 1'b0;
      end
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

@@ hdl/lfpa_dpath.sv @@
// datapath: row bitmap memory, row summary, counters, search and trim logic
module lfpa_dpath #(
   parameter int NUM_PAGES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lfpa_pkg::ctl_cmd_type             cmd,
   output lfpa_pkg::dp_stat_type             stat,
   input  logic [lfpa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [lfpa_pkg::LIMIT_W-1:0]      page_limit,
   output logic [lfpa_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import lfpa_pkg::*;

   localparam int T_W    = $clog2(NUM_PAGES + 1);
   localparam int IDX_W  = $clog2(NUM_PAGES);
   localparam int BIT_W  = (IDX_W - 1 < 5) ? IDX_W - 1 : 5;
   localparam int WORD_W = 2 ** BIT_W;
   localparam int ROW_W  = IDX_W - BIT_W;
   localparam int ROWS   = 2 ** ROW_W;
   localparam int CNT_W  = BIT_W + 1;
   localparam int CMP_W  = (T_W > TOP_CNT_W) ? T_W : TOP_CNT_W;

   logic [T_W-1:0]        top_ff, top_in;
   logic [T_W-1:0]        free_ff, free_in;
   logic [ROWS-1:0]       summary_ff, summary_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [ROW_W-1:0]      row_ff;
   logic [PAGE_W-1:0]     res_page_ff, res_page_in;
   logic [STATUS_W-1:0]   res_st_ff, res_st_in;
   logic                  res_lim_ff, res_lim_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   logic [ROW_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     word;

   logic [MODE_W-1:0]     req_mode;
   logic [IDX_W-1:0]      req_idx;
   logic [CMP_W-1:0]      page_cmp, top_cmp, free_cmp;
   logic [IDX_W-1:0]      page_idx;
   logic [BIT_W-1:0]      page_bit;
   logic                  in_use, in_tail, at_top, release_ok;
   logic [WORD_W-1:0]     freed_word;

   logic [ROW_W-1:0]      low_row;
   logic [BIT_W-1:0]      low_bit;
   logic [WORD_W-1:0]     alloc_word;
   logic                  grow_lim, store_full;

   logic [WORD_W-1:0]     trim_src, cand, keep, trim_word;
   logic [T_W-1:0]        free_base, rowbase, span_full, trim_top, trim_free;
   logic [CNT_W-1:0]      span;
   logic [BIT_W-1:0]      high_bit;
   logic                  found;

   lfpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a row whose summary bit is clear holds no free page, whatever the memory says
   assign word = rd_data & {WORD_W{summary_ff[row_ff]}};

   assign req_mode = req_tdata[MODE_W-1:0];
   assign req_idx  = IDX_W'(req_tdata[MODE_W +: PAGE_W]);

   assign page_cmp   = CMP_W'(page_ff);
   assign top_cmp    = CMP_W'(top_ff);
   assign free_cmp   = CMP_W'(free_ff);
   assign page_idx   = page_cmp[IDX_W-1:0];
   assign page_bit   = page_idx[BIT_W-1:0];
   assign in_use     = (page_ff != '0) && (page_cmp < top_cmp) && !word[page_bit];
   assign in_tail    = page_cmp >= (top_cmp - free_cmp);
   assign at_top     = page_cmp == (top_cmp - CMP_W'(1));
   assign freed_word = word | (WORD_W'(1) << page_bit);
   assign release_ok = in_use && ((mode_ff == MODE_FREE) ||
                                  ((mode_ff == MODE_RELOC) && in_tail));

   // lowest row with a free page
   always_comb begin
      low_row = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (summary_ff[i]) begin
            low_row = ROW_W'(i);
         end
      end
   end

   // lowest free page within the row
   always_comb begin
      low_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   assign alloc_word = word & ~(WORD_W'(1) << low_bit);
   assign grow_lim   = (page_limit != '0) && (top_cmp >= CMP_W'(page_limit));
   assign store_full = top_ff == T_W'(NUM_PAGES);

   // tail trim, one row a step: new top sits just above the highest used page
   assign trim_src  = cmd.trim ? word : freed_word;
   assign free_base = cmd.trim ? free_ff : free_ff + T_W'(1);
   assign rowbase   = T_W'({row_ff, BIT_W'(0)});
   assign span_full = top_ff - rowbase;
   assign span      = span_full[CNT_W-1:0];

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         cand[i] = !trim_src[i] && (CNT_W'(i) < span);
      end
   end

   always_comb begin
      high_bit = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (cand[i]) begin
            high_bit = BIT_W'(i);
         end
      end
   end

   assign found = |cand;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         keep[i] = found && (BIT_W'(i) <= high_bit);
      end
   end

   assign trim_word = trim_src & keep;
   assign trim_top  = found ? rowbase + T_W'(high_bit) + T_W'(1) : rowbase;
   assign trim_free = free_base - (top_ff - trim_top);

   // the trim walks on only while the row just trimmed holds no used page below top
   always_comb begin
      stat            = '0;
      stat.reloc      = mode_ff == MODE_RELOC;
      stat.go_trim    = release_ok && at_top && !found;
      stat.go_realloc = release_ok && (mode_ff == MODE_RELOC) && !(at_top && !found);
      stat.trim_more  = !found;
   end

   always_comb begin
      rd_addr = low_row;
      if (cmd.accept) begin
         rd_addr = (req_mode == MODE_ALLOC) ? low_row : req_idx[IDX_W-1 -: ROW_W];
      end else if (cmd.eval || cmd.trim) begin
         rd_addr = row_ff - ROW_W'(1);
      end
   end

   always_comb begin
      top_in      = top_ff;
      free_in     = free_ff;
      summary_in  = summary_ff;
      mode_in     = mode_ff;
      page_in     = page_ff;
      res_page_in = res_page_ff;
      res_st_in   = res_st_ff;
      res_lim_in  = res_lim_ff;
      wr_en       = 1'b0;
      wr_data     = trim_word;

      if (cmd.accept) begin
         mode_in = req_mode;
         page_in = req_tdata[MODE_W +: PAGE_W];
      end

      if (cmd.issue) begin
         mode_in = MODE_ALLOC;
      end

      if (cmd.eval) begin
         res_page_in = page_ff;
         res_st_in   = ST_OK;
         res_lim_in  = 1'b0;
         case (mode_ff)
            MODE_ALLOC: begin
               if (free_ff != '0) begin
                  wr_en               = 1'b1;
                  wr_data             = alloc_word;
                  summary_in[row_ff]  = |alloc_word;
                  free_in             = free_ff - T_W'(1);
                  res_page_in         = PAGE_W'({row_ff, low_bit});
               end else if (store_full) begin
                  res_page_in = '0;
                  res_st_in   = ST_FULL;
               end else begin
                  res_page_in = PAGE_W'(top_ff);
                  res_lim_in  = grow_lim;
                  top_in      = top_ff + T_W'(1);
               end
            end
            MODE_FREE, MODE_RELOC: begin
               if (!in_use) begin
                  res_st_in = ST_INVALID;
               end else if (release_ok) begin
                  wr_en = 1'b1;
                  if (at_top) begin
                     wr_data            = trim_word;
                     summary_in[row_ff] = |trim_word;
                     top_in             = trim_top;
                     free_in            = trim_free;
                  end else begin
                     wr_data            = freed_word;
                     summary_in[row_ff] = 1'b1;
                     free_in            = free_ff + T_W'(1);
                  end
               end
            end
            default: begin
               res_st_in = ST_INVALID;
            end
         endcase
      end

      if (cmd.trim) begin
         wr_en              = 1'b1;
         wr_data            = trim_word;
         summary_in[row_ff] = |trim_word;
         top_in             = trim_top;
         free_in            = trim_free;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_out) begin
         rsp_in = {(RSP_DATA_W - RSP_FIELD_W)'(0), FREE_CNT_W'(free_ff),
                   TOP_CNT_W'(top_ff), res_lim_ff, res_st_ff, res_page_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= T_W'(1);
         free_ff    <= '0;
         summary_ff <= '0;
      end else begin
         top_ff     <= top_in;
         free_ff    <= free_in;
         summary_ff <= summary_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      page_ff     <= page_in;
      row_ff      <= rd_addr;
      res_page_ff <= res_page_in;
      res_st_ff   <= res_st_in;
      res_lim_ff  <= res_lim_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

endmodule

@@ hdl/lfpa_checker.sv @@
// port checker for the lowest free page allocator and its bind
module lfpa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [lfpa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lfpa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [lfpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [lfpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [lfpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input logic                             csr_pready
);
   import lfpa_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // page 0 is reserved, so top never drops below one
   a_top_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:13] != '0)
      else $error("top count of zero reported");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:10] == ST_OK || rsp_tdata[11:10] == ST_INVALID ||
                      rsp_tdata[11:10] == ST_FULL))
      else $error("unknown status code");

   // rejected or full requests never report growth past the limit
   a_limit_ok_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[11:10] == ST_OK)
      else $error("limit flag with error status");

endmodule

bind lowest_free_page_allocator_unit lfpa_checker u_lfpa_checker (.*);

@@ bench/lowest_free_page_allocator_unit_tb.sv @@
// self-checking testbench of the lowest free page allocator unit
module lowest_free_page_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfpa_pkg::*;

   localparam int NUM_PAGES = 1024;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 50;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] PAGE_LIMIT_ADDR = {REG_PAGE_LIMIT, 2'b00};

   typedef struct {
      logic [PAGE_W-1:0]     page;
      logic [STATUS_W-1:0]   status;
      logic                  limit_hit;
      logic [TOP_CNT_W-1:0]  top;
      logic [FREE_CNT_W-1:0] free;
   } alloc_result_type;

   // shadow copy of the allocator state plus the words still owed on rsp
   class alloc_tracker_type;
      bit free_map [NUM_PAGES];
      int unsigned top_pages;
      int unsigned free_pages;
      int unsigned page_limit;
      alloc_result_type pending_results [$];
      int unsigned errors;

      function new();
         foreach (free_map[i]) free_map[i] = 1'b0;
         top_pages = 1;
         free_pages = 0;
         page_limit = 0;
         errors = 0;
      endfunction

      function bit in_use(int unsigned p);
         return p != 0 && p < top_pages && !free_map[p];
      endfunction

      function void release_page(int unsigned p);
         free_map[p] = 1'b1;
         free_pages++;
         // trim the tail while the page below top is free
         while (top_pages > 1 && free_map[top_pages-1]) begin
            free_map[top_pages-1] = 1'b0;
            top_pages--;
            free_pages--;
         end
      endfunction

      function void grab_page(output logic [PAGE_W-1:0] pg, output logic [STATUS_W-1:0] st,
                              output logic lim);
         lim = 1'b0;
         st = ST_OK;
         pg = '0;
         if (free_pages > 0) begin
            for (int unsigned i = 1; i < top_pages; i++) begin
               if (free_map[i]) begin
                  free_map[i] = 1'b0;
                  free_pages--;
                  pg = i[PAGE_W-1:0];
                  return;
               end
            end
            free_pages = 0;
         end
         if (top_pages >= NUM_PAGES) begin
            st = ST_FULL;
            return;
         end
         lim = page_limit > 0 && top_pages >= page_limit;
         pg = top_pages[PAGE_W-1:0];
         top_pages++;
      endfunction

      function void track_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] page);
         alloc_result_type r;
         r.page = page;
         r.status = ST_OK;
         r.limit_hit = 1'b0;
         case (mode)
            MODE_ALLOC: grab_page(r.page, r.status, r.limit_hit);
            MODE_FREE: begin
               if (in_use(page)) release_page(page);
               else r.status = ST_INVALID;
            end
            MODE_RELOC: begin
               if (!in_use(page)) begin
                  r.status = ST_INVALID;
               end else if (page >= top_pages - free_pages) begin
                  release_page(page);
                  grab_page(r.page, r.status, r.limit_hit);
               end
            end
            default: r.status = ST_INVALID;
         endcase
         r.top = top_pages[TOP_CNT_W-1:0];
         r.free = free_pages[FREE_CNT_W-1:0];
         pending_results = {pending_results, r};
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] word);
         alloc_result_type r;
         if (pending_results.size() == 0) begin
            $error("rsp word %h arrived with no request outstanding", word);
            errors++;
            return;
         end
         r = pending_results[0];
         pending_results.delete(0);
         if (word[9:0] !== r.page) begin
            $error("result_page: expected %0d, got %0d", r.page, word[9:0]);
            errors++;
         end
         if (word[11:10] !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, word[11:10]);
            errors++;
         end
         if (word[12] !== r.limit_hit) begin
            $error("limit_reached: expected %0d, got %0d", r.limit_hit, word[12]);
            errors++;
         end
         if (word[23:13] !== r.top) begin
            $error("top_count: expected %0d, got %0d", r.top, word[23:13]);
            errors++;
         end
         if (word[33:24] !== r.free) begin
            $error("free_count: expected %0d, got %0d", r.free, word[33:24]);
            errors++;
         end
      endfunction

      // random page in use, anywhere below top or only in the tail region
      function int unsigned pick_page(bit tail_only);
         int unsigned lo;
         int unsigned cand [$];
         lo = tail_only ? top_pages - free_pages : 1;
         if (lo == 0) lo = 1;
         for (int unsigned p = lo; p < top_pages; p++) begin
            if (!free_map[p]) cand = {cand, p};
         end
         if (cand.size() == 0) return 0;
         return cand[$urandom_range(0, cand.size() - 1)];
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   alloc_tracker_type tracker;
   int burst_left = 0;
   int ready_style = 0;
   int style_left = 0;
   int idle_cycles = 0;

   lowest_free_page_allocator_unit #(.NUM_PAGES(NUM_PAGES)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rsp side: check accepted words, then pick the ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_word(rsp_tdata);
      if (style_left == 0) begin
         ready_style <= $urandom_range(0, 3);
         style_left <= $urandom_range(10, 150);
      end else begin
         style_left <= style_left - 1;
      end
      case (ready_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ~rsp_tready;
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page);
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-MODE_W-PAGE_W){1'b0}}, page, mode};
      do @(posedge clock); while (!req_tready);
      tracker.track_request(mode, page);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(0, 25);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= PAGE_LIMIT_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write && csr_prdata !== value) begin
         $error("page_limit readback: expected %0d, got %0d", value, csr_prdata);
         tracker.errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic change_limit(input int unsigned value);
      wait_drained();
      // pause before the csr access; every trim ends before its word leaves
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, value);
      tracker.page_limit = value;
      @(posedge clock);
      csr_access(1'b0, value);
   endtask

   task automatic random_items(input int count, input int alloc_pct, input int free_pct,
                               input int reloc_pct);
      int r;
      logic [MODE_W-1:0] m;
      int unsigned p;
      repeat (count) begin
         r = $urandom_range(0, 99);
         p = $urandom_range(0, NUM_PAGES - 1);
         if (r < alloc_pct) begin
            m = MODE_ALLOC;
         end else if (r < alloc_pct + free_pct) begin
            m = MODE_FREE;
            // freeing the page below top drives the tail trim
            if ($urandom_range(0, 2) == 0 && tracker.in_use(tracker.top_pages - 1)) begin
               p = tracker.top_pages - 1;
            end else if (tracker.pick_page(1'b0) != 0) begin
               p = tracker.pick_page(1'b0);
            end
         end else if (r < alloc_pct + free_pct + reloc_pct) begin
            m = MODE_RELOC;
            if ($urandom_range(0, 3) != 0 && tracker.pick_page(1'b1) != 0) begin
               p = tracker.pick_page(1'b1);
            end else if (tracker.pick_page(1'b0) != 0) begin
               p = tracker.pick_page(1'b0);
            end
         end else begin
            m = MODE_W'($urandom_range(0, 3));
         end
         send_word(m, p[PAGE_W-1:0]);
         if ($urandom_range(0, 99) == 0) wait_drained();
      end
   endtask

   initial begin
      tracker = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      rsp_tready <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: invalid pages, unused mode, holes, relocation and trim
      send_word(MODE_FREE, 10'd0);
      send_word(MODE_RELOC, 10'd0);
      send_word(MODE_ALLOC, 10'd1023);
      send_word(MODE_ALLOC, 10'd0);
      send_word(MODE_ALLOC, 10'd0);
      send_word(MODE_UNUSED, 10'd1023);
      send_word(MODE_FREE, 10'd1023);
      send_word(MODE_FREE, 10'd2);
      send_word(MODE_FREE, 10'd2);
      send_word(MODE_RELOC, 10'd2);
      send_word(MODE_RELOC, 10'd1);
      send_word(MODE_RELOC, 10'd3);
      repeat (3) send_word(MODE_ALLOC, 10'd0);
      send_word(MODE_FREE, 10'd3);
      send_word(MODE_FREE, 10'd4);
      send_word(MODE_FREE, 10'd5);
      send_word(MODE_ALLOC, 10'd0);
      send_word(MODE_RELOC, 10'd1023);

      change_limit($urandom_range(2, 40));
      random_items(150, 45, 25, 15);
      change_limit(1);
      random_items(100, 50, 20, 15);
      change_limit(0);
      random_items(150, 40, 30, 20);

      // limits near the size of the store
      change_limit(1023);
      random_items(60, 30, 40, 20);

      change_limit(1024);
      random_items(120, 20, 45, 25);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending_results.size() != 0) begin
         $error("%0d rsp words never arrived", tracker.pending_results.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
